### rtl/stmm_pkg.sv
// Package for the sparse-table range min/max block.
// Holds sizes, item kinds, status codes, sequencer states and the RAM control bundle.
// No dependencies.
package stmm_pkg;

    localparam int DEPTH      = 1024;
    localparam int LEVELS     = 11;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ADDR_W    = LVL_W + IDX_W;
    localparam int MEM_WORDS = LEVELS * DEPTH;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_BUILD = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_UNBUILT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_QRY_RD,
        ST_QRY_CMP,
        ST_BLD_RD,
        ST_BLD_WR,
        ST_RESP
    } state_t;

    // Shared by the min and max table RAMs: one write port, two read ports.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } ram_ctl_t;

endpackage

### rtl/stmm_ram.sv
// Table RAM for one sparse table (all levels): one write port, two registered read ports.
// Depends on stmm_pkg.
module stmm_ram
    import stmm_pkg::*;
(
    input  logic     clk,
    input  ram_ctl_t ctl,
    input  value_t   wdata,
    output value_t   rdata_a,
    output value_t   rdata_b
);

    value_t mem [0:MEM_WORDS-1];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= wdata;
        end
        rdata_a <= mem[ctl.raddr_a];
        rdata_b <= mem[ctl.raddr_b];
    end

endmodule

### rtl/stmm_minmax.sv
// Shared signed compare unit: minimum of one pair, maximum of another.
// Depends on stmm_pkg.
module stmm_minmax
    import stmm_pkg::*;
(
    input  value_t min_a,
    input  value_t min_b,
    input  value_t max_a,
    input  value_t max_b,
    output value_t lo,
    output value_t hi
);

    assign lo = (min_a < min_b) ? min_a : min_b;
    assign hi = (max_a > max_b) ? max_a : max_b;

endmodule

### rtl/sparse_table_range_min_max_top.sv
// Top level of the sparse-table range min/max block: sequencer, item and result registers.
// Depends on stmm_pkg, stmm_ram and stmm_minmax.
//
// The block keeps up to 1024 signed 32-bit elements in a sparse table of 11 levels for both
// minimum and maximum, each held in one RAM with one write and two registered read ports.
// Items are taken one at a time: s_tready is high only while the sequencer is idle. A load
// or clear item passes through its own step and then the response state, which holds until
// the output register is free; a query issues both block reads, then compares (skipped on a
// bad range or unbuilt table) and responds. A build walks level 1 up to level 10, reading
// both halves of each entry in one step, then comparing and writing in the next, and ends
// early at the first level that has no entries. The output register frees the input side:
// the next item is accepted while a result waits on m_tready.
// Every item gives one result; status is ok, bad range, table full or query before build,
// and min/max are zero unless the query succeeded.
module sparse_table_range_min_max_top
    import stmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // value[31:0], left_index[41:32], right_index[51:42], zeros
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // range_min[31:0], range_max[63:32]
    output logic [1:0]  m_tuser    // status[1:0]
);

    state_t state_reg, state_next;

    // Latched item
    kind_t             kind_reg;
    value_t            value_reg;
    logic [IDX_W-1:0]  left_reg, right_reg;

    // Table bookkeeping
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              built_reg, built_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Pending result
    status_t           res_stat_reg, res_stat_next;
    value_t            res_min_reg, res_min_next;
    value_t            res_max_reg, res_max_next;

    // Output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    ram_ctl_t          ram_ctl;
    value_t            wdata_min, wdata_max;
    value_t            rd_min_a, rd_min_b, rd_max_a, rd_max_b;
    value_t            cmp_lo, cmp_hi;

    logic              s_accept;
    logic              out_free;
    logic              qry_bad;
    logic [CNT_W-1:0]  qry_len;
    logic [LVL_W-1:0]  qry_lvl_raw, qry_lvl;
    logic [CNT_W-1:0]  qry_pow;
    logic [IDX_W-1:0]  qry_second;
    logic [CNT_W:0]    bld_span, bld_end;
    logic              bld_fits;
    logic [LVL_W-1:0]  bld_src_lvl;
    logic [IDX_W-1:0]  bld_partner;
    logic              bld_last_lvl;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Query: range check, level = floor(log2(length)), start of the second block
    assign qry_bad = (left_reg > right_reg) || ({1'b0, right_reg} >= cnt_reg);
    assign qry_len = {1'b0, right_reg} - {1'b0, left_reg} + CNT_W'(1);

    always_comb
    begin
        qry_lvl_raw = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (qry_len[i])
            begin
                qry_lvl_raw = LVL_W'(i);
            end
        end
    end

    assign qry_lvl    = (qry_lvl_raw > LVL_W'(LEVELS - 1)) ? LVL_W'(LEVELS - 1) : qry_lvl_raw;
    assign qry_pow    = CNT_W'(1) << qry_lvl;
    assign qry_second = IDX_W'({1'b0, right_reg} + CNT_W'(1) - qry_pow);

    // Build: entry idx of level lvl exists while idx + 2^lvl <= count
    assign bld_span     = (CNT_W + 1)'(1) << lvl_reg;
    assign bld_end      = {1'b0, {(CNT_W - IDX_W){1'b0}}, idx_reg} + bld_span;
    assign bld_fits     = bld_end <= {1'b0, cnt_reg};
    assign bld_src_lvl  = lvl_reg - LVL_W'(1);
    assign bld_partner  = idx_reg + IDX_W'(bld_span >> 1);
    assign bld_last_lvl = (lvl_reg == LVL_W'(LEVELS - 1)) || (idx_reg == '0);

    // RAM port control
    always_comb
    begin
        ram_ctl.we      = 1'b0;
        ram_ctl.waddr   = {lvl_reg, idx_reg};
        ram_ctl.raddr_a = {bld_src_lvl, idx_reg};
        ram_ctl.raddr_b = {bld_src_lvl, bld_partner};
        wdata_min       = cmp_lo;
        wdata_max       = cmp_hi;
        unique case (state_reg)
            ST_LOAD:
            begin
                ram_ctl.we    = (cnt_reg != CNT_W'(DEPTH));
                ram_ctl.waddr = {LVL_W'(0), cnt_reg[IDX_W-1:0]};
                wdata_min     = value_reg;
                wdata_max     = value_reg;
            end
            ST_QRY_RD:
            begin
                ram_ctl.raddr_a = {qry_lvl, left_reg};
                ram_ctl.raddr_b = {qry_lvl, qry_second};
            end
            ST_BLD_WR:
            begin
                ram_ctl.we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    stmm_ram u_min_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wdata   (wdata_min),
        .rdata_a (rd_min_a),
        .rdata_b (rd_min_b)
    );

    stmm_ram u_max_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wdata   (wdata_max),
        .rdata_a (rd_max_a),
        .rdata_b (rd_max_b)
    );

    stmm_minmax u_minmax (
        .min_a (rd_min_a),
        .min_b (rd_min_b),
        .max_a (rd_max_a),
        .max_b (rd_max_b),
        .lo    (cmp_lo),
        .hi    (cmp_hi)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (kind_t'(s_tuser))
                        KIND_LOAD:  state_next = ST_LOAD;
                        KIND_BUILD: state_next = ST_BLD_RD;
                        KIND_QUERY: state_next = ST_QRY_RD;
                        KIND_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:    state_next = ST_RESP;
            ST_CLEAR:   state_next = ST_RESP;
            ST_QRY_RD:  state_next = (!built_reg || qry_bad) ? ST_RESP : ST_QRY_CMP;
            ST_QRY_CMP: state_next = ST_RESP;
            ST_BLD_RD:
            begin
                if (bld_fits)
                begin
                    state_next = ST_BLD_WR;
                end
                else if (bld_last_lvl)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_BLD_WR:  state_next = ST_BLD_RD;
            ST_RESP:    state_next = out_free ? ST_IDLE : ST_RESP;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and result updates
    always_comb
    begin
        cnt_next      = cnt_reg;
        built_next    = built_reg;
        lvl_next      = lvl_reg;
        idx_next      = idx_reg;
        res_stat_next = res_stat_reg;
        res_min_next  = res_min_reg;
        res_max_next  = res_max_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Start a build at level 1, entry 0; clear the result fields
                lvl_next      = LVL_W'(1);
                idx_next      = '0;
                res_stat_next = STAT_OK;
                res_min_next  = '0;
                res_max_next  = '0;
            end
            ST_LOAD:
            begin
                if (cnt_reg == CNT_W'(DEPTH))
                begin
                    res_stat_next = STAT_FULL;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    built_next = 1'b0;
                end
            end
            ST_CLEAR:
            begin
                cnt_next   = '0;
                built_next = 1'b0;
            end
            ST_QRY_RD:
            begin
                if (!built_reg)
                begin
                    res_stat_next = STAT_UNBUILT;
                end
                else if (qry_bad)
                begin
                    res_stat_next = STAT_RANGE;
                end
            end
            ST_QRY_CMP:
            begin
                res_min_next = cmp_lo;
                res_max_next = cmp_hi;
            end
            ST_BLD_RD:
            begin
                if (!bld_fits)
                begin
                    if (bld_last_lvl)
                    begin
                        built_next = 1'b1;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LVL_W'(1);
                        idx_next = '0;
                    end
                end
            end
            ST_BLD_WR:
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_max_reg, res_min_reg};
                    m_tuser_next  = res_stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            built_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            built_reg    <= built_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg  <= kind_t'(s_tuser);
            value_reg <= s_tdata[31:0];
            left_reg  <= s_tdata[41:32];
            right_reg <= s_tdata[51:42];
        end
        lvl_reg      <= lvl_next;
        idx_reg      <= idx_next;
        res_stat_reg <= res_stat_next;
        res_min_reg  <= res_min_next;
        res_max_reg  <= res_max_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("element count above table depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("failed result carries nonzero data");

    a_bld_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLD_RD || state_reg == ST_BLD_WR)
        |-> (lvl_reg != '0 && lvl_reg <= LVL_W'(LEVELS - 1)))
        else $error("build level out of range");

    a_load_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (kind_reg == KIND_LOAD))
        else $error("load step entered for another item kind");

    a_build_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLD_RD && state_next == ST_RESP) |=> built_reg)
        else $error("finished build left table unbuilt");
`endif

endmodule

### sim/testbench.sv
// Self-checking bench for sparse_table_range_min_max_top: a clocked driver and monitor
// around the block, checked against a behavioral sparse table kept in the bench.
// Depends on stmm_pkg and the block's RTL.
module testbench;
    import stmm_pkg::*;

    localparam int     STALL_LIMIT  = 100000;  // cycles with no item moving on either side
    localparam int     RANDOM_ITEMS = 60;
    localparam int     HOLD_AFTER   = 50;      // results seen before the long receiver hold
    localparam int     HOLD_CYCLES  = 300;
    localparam int     MAX_REPORTS  = 10;
    localparam int     PAD_W        = 56 - VALUE_BITS - 2 * IDX_W;
    localparam value_t VAL_MIN      = {1'b1, {(VALUE_BITS - 1){1'b0}}};
    localparam value_t VAL_MAX      = {1'b0, {(VALUE_BITS - 1){1'b1}}};

    typedef struct {
        kind_t            kind;
        value_t           value;
        logic [IDX_W-1:0] left_idx;
        logic [IDX_W-1:0] right_idx;
    } table_item_t;

    typedef struct {
        status_t status;
        value_t  range_lo;
        value_t  range_hi;
    } range_answer_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // value[31:0], left_index[41:32], right_index[51:42], zeros
    logic [1:0]  s_tuser  = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // range_min[31:0], range_max[63:32]
    logic [1:0]  m_tuser;         // status[1:0]

    sparse_table_range_min_max_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioral sparse table: level 0 holds the loaded elements, level j
    // entry i covers elements i .. i + 2^j - 1.
    // ------------------------------------------------------------------
    value_t        min_tab [LEVELS][DEPTH];
    value_t        max_tab [LEVELS][DEPTH];
    int            elem_count = 0;
    bit            is_built   = 1'b0;
    range_answer_t answers_due[$];
    int            kind_seen [4];
    int            status_seen [4];

    // Advance the table by one accepted item and queue the result it owes.
    task automatic apply_item(input table_item_t it);
        range_answer_t ans;
        int            lvl, span, half, i, l, r, second;
        value_t        a, b;
        ans.status   = STAT_OK;
        ans.range_lo = '0;
        ans.range_hi = '0;
        kind_seen[it.kind]++;
        case (it.kind)
            KIND_LOAD:
                if (elem_count >= DEPTH)
                    ans.status = STAT_FULL;     // full table: drop the element
                else
                begin
                    min_tab[0][elem_count] = it.value;
                    max_tab[0][elem_count] = it.value;
                    elem_count++;
                    is_built = 1'b0;            // any load invalidates the upper levels
                end
            KIND_BUILD:
            begin
                for (lvl = 1; lvl < LEVELS; lvl++)
                begin
                    span = 1 << lvl;
                    half = span >> 1;
                    for (i = 0; i + span <= elem_count; i++)
                    begin
                        a = min_tab[lvl-1][i];
                        b = min_tab[lvl-1][i+half];
                        min_tab[lvl][i] = (a < b) ? a : b;
                        a = max_tab[lvl-1][i];
                        b = max_tab[lvl-1][i+half];
                        max_tab[lvl][i] = (a > b) ? a : b;
                    end
                end
                is_built = 1'b1;
            end
            KIND_QUERY:
            begin
                l = it.left_idx;
                r = it.right_idx;
                // The not-built check wins over the range check.
                if (!is_built)
                    ans.status = STAT_UNBUILT;
                else if (l > r || r >= elem_count)
                    ans.status = STAT_RANGE;
                else
                begin
                    lvl = 0;
                    while (((r - l + 1) >> (lvl + 1)) != 0)
                        lvl++;
                    if (lvl > LEVELS - 1)
                        lvl = LEVELS - 1;
                    second = r + 1 - (1 << lvl);
                    a = min_tab[lvl][l];
                    b = min_tab[lvl][second];
                    ans.range_lo = (a < b) ? a : b;
                    a = max_tab[lvl][l];
                    b = max_tab[lvl][second];
                    ans.range_hi = (a > b) ? a : b;
                end
            end
            KIND_CLEAR:
            begin
                elem_count = 0;
                is_built   = 1'b0;
            end
        endcase
        status_seen[ans.status]++;
        answers_due.push_back(ans);
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation. gen_count mirrors the element count so that most
    // queries can be aimed inside the loaded range.
    // ------------------------------------------------------------------
    table_item_t items_to_send[$];
    int          gen_count    = 0;
    int          items_pushed = 0;

    function automatic value_t pick_value();
        case ($urandom_range(0, 5))
            0:       pick_value = $urandom_range(0, 8) - 4;   // small values force ties
            1:       pick_value = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            default: pick_value = $urandom;
        endcase
    endfunction

    task automatic push_item(input kind_t k, input value_t v, input int l, input int r);
        table_item_t it;
        it.kind      = k;
        it.value     = v;
        it.left_idx  = l[IDX_W-1:0];
        it.right_idx = r[IDX_W-1:0];
        items_to_send.push_back(it);
        items_pushed++;
        if (k == KIND_LOAD && gen_count < DEPTH)
            gen_count++;
        else if (k == KIND_CLEAR)
            gen_count = 0;
    endtask

    // Aim a query inside the loaded elements (random when none are loaded): whole table, one element or any span.
    task automatic push_valid_query();
        int l, r;
        if (gen_count == 0)
        begin
            push_item(KIND_QUERY, $urandom, $urandom, $urandom);
            return;
        end
        case ($urandom_range(0, 3))
            0:
            begin
                l = 0;
                r = gen_count - 1;
            end
            1:
            begin
                l = $urandom_range(0, gen_count - 1);
                r = l;
            end
            default:
            begin
                l = $urandom_range(0, gen_count - 1);
                r = $urandom_range(l, gen_count - 1);
            end
        endcase
        push_item(KIND_QUERY, $urandom, l, r);
    endtask

    // Well-formed run: usually a clear, then load, build, then queries with the odd stray item.
    task automatic push_sequence();
        int n, q, k;
        if (gen_count > 400 || $urandom_range(0, 3) != 0)
            push_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        for (k = 0; k < n; k++)
            push_item(KIND_LOAD, pick_value(), $urandom, $urandom);
        push_item(KIND_BUILD, $urandom, $urandom, $urandom);
        q = $urandom_range(4, 16);
        for (k = 0; k < q; k++)
            case ($urandom_range(0, 9))
                0: push_item(KIND_QUERY, $urandom, $urandom, $urandom);
                1:
                begin
                    // A late load drops the built state until the next build.
                    push_item(KIND_LOAD, pick_value(), $urandom, $urandom);
                    push_valid_query();
                    push_item(KIND_BUILD, $urandom, $urandom, $urandom);
                end
                default: push_valid_query();
            endcase
    endtask

    task automatic push_noise();
        int n, k;
        n = $urandom_range(4, 12);
        for (k = 0; k < n; k++)
            push_item(kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items, hold each until accepted, and insert
    // idle bursts in alternating stretches of 128 items.
    // ------------------------------------------------------------------
    table_item_t on_bus;
    int          src_gap    = 0;
    int          items_sent = 0;
    bit          idle_on    = 1'b1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_item(on_bus);
                items_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (items_to_send.size() > 0)
                begin
                    on_bus = items_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{PAD_W{1'b0}}, on_bus.right_idx, on_bus.left_idx, on_bus.value};
                    s_tuser  <= on_bus.kind;
                    if (idle_on && (items_sent / 128) % 2 == 0 && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 9);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every result against the oldest expected answer, and
    // drive m_tready with random stalls plus one long hold-off that fills
    // the block and backs up the input side.
    // ------------------------------------------------------------------
    int            sink_gap     = 0;
    int            hold_left    = 0;
    bit            hold_done    = 1'b0;
    int            results_seen = 0;
    int            fail_count   = 0;
    range_answer_t due;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (answers_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result %0d: status %0d min %0d max %0d",
                                 results_seen, m_tuser, $signed(m_tdata[31:0]),
                                 $signed(m_tdata[63:32]));
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (m_tuser !== due.status || m_tdata[31:0] !== due.range_lo ||
                        m_tdata[63:32] !== due.range_hi)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result %0d mismatch: expected status %0d min %0d max %0d,",
                                      " got status %0d min %0d max %0d"},
                                     results_seen, due.status, due.range_lo, due.range_hi,
                                     m_tuser, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && (results_seen / 96) % 2 == 0 && $urandom_range(0, 4) == 0)
                    sink_gap = $urandom_range(1, 9);
            end
        end
    end

    // Watchdog: flag the run when nothing moves for too long.
    int quiet_cycles = 0;
    bit timed_out    = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else if (!timed_out)
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end
    end

    // Sample at the falling edge, clear of the driver and monitor updates.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (!timed_out &&
               (items_to_send.size() > 0 || s_tvalid || answers_due.size() > 0));
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed items, random runs, then a full table
    // with no idling.
    // ------------------------------------------------------------------
    initial
    begin
        int k, base, leftover;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Query on a never-built table, then build with nothing loaded.
        push_item(KIND_QUERY, '0, 0, 0);
        push_item(KIND_BUILD, '0, 0, 0);
        push_item(KIND_QUERY, '0, 0, 0);
        push_item(KIND_LOAD, VAL_MIN, 0, 0);
        push_item(KIND_LOAD, VAL_MAX, 0, 0);
        push_item(KIND_LOAD, '0, 0, 0);
        push_item(KIND_LOAD, -1, 0, 0);
        push_item(KIND_LOAD, 1, 0, 0);
        // Loads after the earlier build leave the table unbuilt.
        push_item(KIND_QUERY, '0, 0, 4);
        push_item(KIND_BUILD, '0, 0, 0);
        push_item(KIND_QUERY, '0, 0, 4);
        push_item(KIND_QUERY, '0, 1, 1);
        push_item(KIND_QUERY, '0, 0, 1);
        push_item(KIND_QUERY, '0, 2, 4);
        // Reversed range, right edge past the count, indices at the top.
        push_item(KIND_QUERY, '0, 3, 1);
        push_item(KIND_QUERY, '0, 0, 5);
        push_item(KIND_QUERY, '0, DEPTH - 1, DEPTH - 1);
        push_item(KIND_QUERY, '0, 0, DEPTH - 1);
        push_item(KIND_LOAD, 5, 0, 0);
        push_item(KIND_QUERY, '0, 0, 5);
        push_item(KIND_BUILD, '0, 0, 0);
        push_item(KIND_QUERY, '0, 0, 5);
        push_item(KIND_CLEAR, '0, 0, 0);
        push_item(KIND_QUERY, '0, 0, 0);
        wait_drained();

        // Mostly well-formed runs with random content, some noise.
        base = items_pushed;
        while (items_pushed - base < RANDOM_ITEMS)
            if ($urandom_range(0, 9) < 8)
                push_sequence();
            else
                push_noise();
        wait_drained();

        // Fill the table to the top, overflow it, and query the widest spans.
        idle_on = 1'b0;
        push_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        for (k = 0; k < DEPTH + 3; k++)
            push_item(KIND_LOAD, pick_value(), $urandom, $urandom);
        push_item(KIND_BUILD, $urandom, $urandom, $urandom);
        push_item(KIND_QUERY, $urandom, 0, DEPTH - 1);
        push_item(KIND_QUERY, $urandom, DEPTH - 1, DEPTH - 1);
        push_item(KIND_QUERY, $urandom, 0, 0);
        push_item(KIND_QUERY, $urandom, DEPTH / 2, DEPTH - 1);
        push_item(KIND_QUERY, $urandom, DEPTH - 1, DEPTH - 2);
        for (k = 0; k < 20; k++)
            push_valid_query();
        push_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        push_item(KIND_QUERY, $urandom, 0, 0);
        wait_drained();
        repeat (20) @(posedge clk);

        if (timed_out)
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        leftover = answers_due.size();
        if (leftover > 0)
            $display("%0d expected results never arrived", leftover);
        $display("Run covered %0d items (%0d loads, %0d builds, %0d queries, %0d clears), %0d results checked.",
                 items_sent, kind_seen[KIND_LOAD], kind_seen[KIND_BUILD],
                 kind_seen[KIND_QUERY], kind_seen[KIND_CLEAR], results_seen);
        $display("Statuses predicted: ok %0d, bad range %0d, table full %0d, not built %0d; %0d failures.",
                 status_seen[STAT_OK], status_seen[STAT_RANGE], status_seen[STAT_FULL],
                 status_seen[STAT_UNBUILT], fail_count);
        if (!timed_out && fail_count == 0 && leftover == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
